[hdl/stc_pkg.sv]
// Shared types, constants and lookup tables for the scancode decoder.
// Depends on nothing; every other file of the block imports it.
package stc_pkg;

	// Special set-1 scancodes.
	localparam logic [7:0] CODE_EXT_PREFIX = 8'hE0;
	localparam logic [7:0] CODE_LSHIFT_MK  = 8'h2A;
	localparam logic [7:0] CODE_RSHIFT_MK  = 8'h36;
	localparam logic [7:0] CODE_LSHIFT_BK  = 8'hAA;
	localparam logic [7:0] CODE_RSHIFT_BK  = 8'hB6;
	localparam logic [7:0] CODE_CAPS_MK    = 8'h3A;

	// LED mask sent with the keyboard "set LEDs" command.
	localparam logic [2:0] LED_CAPS_ON  = 3'd4;
	localparam logic [2:0] LED_CAPS_OFF = 3'd0;

	// Number of make codes covered by the character tables.
	localparam int unsigned TABLE_LEN = 84;

	localparam logic [6:0] PLAIN_MAP [0:TABLE_LEN-1] = '{
		7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
		7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
		7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
		7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
		7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
		7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
		7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h30, 7'h7F
	};

	localparam logic [6:0] UPPER_MAP [0:TABLE_LEN-1] = '{
		7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
		7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
		7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
		7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
		7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
		7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
		7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
		7'h38, 7'h39, 7'h00, 7'h34, 7'h35, 7'h36, 7'h00, 7'h31,
		7'h32, 7'h33, 7'h30, 7'h7F
	};

	// One scancode together with the keyboard flags that applied to it.
	typedef struct packed {
		logic [7:0] code;
		logic       upper;
		logic       ext;
		logic       led_write;
		logic [2:0] led_mask;
	} stc_stage_t;

	// One decoded result.
	typedef struct packed {
		logic [6:0] ascii_char;
		logic       led_write;
		logic [2:0] led_mask;
	} stc_result_t;

	// Table read; make codes past the tables give no character.
	function automatic logic [6:0] map_lookup(input logic [6:0] idx, input logic upper);
		logic [6:0] res;
		res = 7'h00;
		if (32'(idx) < TABLE_LEN) begin
			res = upper ? UPPER_MAP[idx] : PLAIN_MAP[idx];
		end
		return res;
	endfunction

endpackage

[hdl/scancode_to_ascii_decoder.sv]
// Top level of the set-1 scancode to ASCII decoder: pipeline control and result register.
// Depends on stc_pkg, stc_front and stc_lookup.
//
// Every scancode beat gives exactly one result beat: an ASCII character (0 for none) and a
// request to send the keyboard LED command with its mask when caps lock toggles. The input
// register captures the code with the keyboard flags, the table lookup runs between the two
// registers, and the result register presents it. A new beat is accepted every cycle while
// results are taken; the result register and the input stage together hold two beats, so a
// stalled output fills both before in_ready falls.
module scancode_to_ascii_decoder
	import stc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] scan_code,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [6:0] ascii_char,
	output logic       led_write,
	output logic [2:0] led_mask
);

	stc_stage_t  stage_s1;
	stc_result_t result;
	stc_result_t result_q;
	logic        valid_s1;
	logic        out_valid_q;
	logic        accept;
	logic        advance;

	// Handshake: stage one moves on when the result register is free or being emptied.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;

	stc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.scan_code (scan_code),
		.stage_s1  (stage_s1)
	);

	stc_lookup u_lookup (
		.stage_s1 (stage_s1),
		.result   (result)
	);

	// Valid flags of both stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign out_valid  = out_valid_q;
	assign ascii_char = result_q.ascii_char;
	assign led_write  = result_q.led_write;
	assign led_mask   = result_q.led_mask;

endmodule

[hdl/stc_front.sv]
// Input stage: keyboard flag registers and the stage-one beat register.
// Depends on stc_pkg.
module stc_front
	import stc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] scan_code,
	output stc_stage_t stage_s1
);

	logic ext_q;
	logic lshift_q;
	logic rshift_q;
	logic caps_q;
	logic caps_next;
	logic is_special;

	// Shift and caps codes act on their flags whatever the prefix state.
	assign is_special = (scan_code == CODE_EXT_PREFIX) || (scan_code == CODE_LSHIFT_MK)
		|| (scan_code == CODE_RSHIFT_MK) || (scan_code == CODE_LSHIFT_BK)
		|| (scan_code == CODE_RSHIFT_BK) || (scan_code == CODE_CAPS_MK);
	assign caps_next = caps_q ^ (scan_code == CODE_CAPS_MK);

	// Flag update on every accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_q    <= 1'b0;
			lshift_q <= 1'b0;
			rshift_q <= 1'b0;
			caps_q   <= 1'b0;
		end else if (accept) begin
			case (scan_code)
				CODE_EXT_PREFIX: ext_q <= 1'b1;
				CODE_LSHIFT_MK:  lshift_q <= 1'b1;
				CODE_RSHIFT_MK:  rshift_q <= 1'b1;
				CODE_LSHIFT_BK:  lshift_q <= 1'b0;
				CODE_RSHIFT_BK:  rshift_q <= 1'b0;
				CODE_CAPS_MK:    caps_q <= caps_next;
				default:         ext_q <= 1'b0;
			endcase
		end
	end

	// Capture the code with the flags as they stood before this beat; the LED mask takes the new caps state.
	always_ff @(posedge clk) begin
		if (accept) begin
			stage_s1.code      <= scan_code;
			stage_s1.upper     <= (lshift_q | rshift_q) ^ caps_q;
			stage_s1.ext       <= ext_q & ~is_special;
			stage_s1.led_write <= (scan_code == CODE_CAPS_MK);
			stage_s1.led_mask  <= ((scan_code == CODE_CAPS_MK) && caps_next)
				? LED_CAPS_ON : LED_CAPS_OFF;
		end
	end

endmodule

[hdl/stc_lookup.sv]
// Character decode: selects a table entry or no character for one beat.
// Depends on stc_pkg.
module stc_lookup
	import stc_pkg::*;
(
	input  stc_stage_t  stage_s1,
	output stc_result_t result
);

	logic no_char;

	// Prefix, shift, caps, discarded and release codes give no character.
	assign no_char = stage_s1.ext || stage_s1.code[7]
		|| (stage_s1.code == CODE_LSHIFT_MK) || (stage_s1.code == CODE_RSHIFT_MK)
		|| (stage_s1.code == CODE_CAPS_MK);

	always_comb begin
		result.ascii_char = no_char ? 7'h00
			: map_lookup(stage_s1.code[6:0], stage_s1.upper);
		result.led_write  = stage_s1.led_write;
		result.led_mask   = stage_s1.led_mask;
	end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// Self-checking bench for the set-1 scancode to ASCII decoder: a directed table, then random
// keystroke traffic, every result checked against its row or a model. Depends on stc_pkg.
module testbench
	import stc_pkg::*;
;

	localparam int unsigned KEY_COUNT   = 84;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned DRAIN_WAIT  = 12;
	localparam int unsigned ITEM_GOAL   = 1450;

	// Character tables of the keyboard, unshifted and shifted.
	localparam logic [6:0] LOWER_KEYS [0:KEY_COUNT-1] = '{
		7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
		7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
		7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68,
		7'h6A, 7'h6B, 7'h6C, 7'h3B, 7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
		7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h30, 7'h7F
	};
	localparam logic [6:0] SHIFT_KEYS [0:KEY_COUNT-1] = '{
		7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29,
		7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
		7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48,
		7'h4A, 7'h4B, 7'h4C, 7'h3A, 7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
		7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
		7'h38, 7'h39, 7'h00, 7'h34, 7'h35, 7'h36, 7'h00, 7'h31, 7'h32, 7'h33, 7'h30, 7'h7F
	};

	// One row of the directed table; fixed rows carry their result, the rest use the model.
	typedef struct packed {
		logic [7:0] code;
		logic       fixed;
		logic [6:0] ascii_char;
		logic       led_write;
		logic [2:0] led_mask;
	} key_row_t;

	localparam int unsigned ROW_COUNT = 24;
	localparam key_row_t KEY_ROWS [0:ROW_COUNT-1] = '{
		'{8'h1E, 1'b1, 7'h61, 1'b0, LED_CAPS_OFF},          // 'a' straight after reset
		'{8'h00, 1'b1, 7'h00, 1'b0, LED_CAPS_OFF},          // lowest code, empty entry
		'{8'h53, 1'b1, 7'h7F, 1'b0, LED_CAPS_OFF},          // last table entry
		'{8'h54, 1'b1, 7'h00, 1'b0, LED_CAPS_OFF},          // first code past the tables
		'{8'h7F, 1'b1, 7'h00, 1'b0, LED_CAPS_OFF},          // highest make code
		'{8'hFF, 1'b1, 7'h00, 1'b0, LED_CAPS_OFF},          // highest release code
		'{8'h9E, 1'b1, 7'h00, 1'b0, LED_CAPS_OFF},          // release of 'a'
		'{CODE_EXT_PREFIX, 1'b1, 7'h00, 1'b0, LED_CAPS_OFF},
		'{CODE_LSHIFT_MK, 1'b1, 7'h00, 1'b0, LED_CAPS_OFF}, // shift under a prefix
		'{8'h1E, 1'b1, 7'h00, 1'b0, LED_CAPS_OFF},          // swallowed by the prefix
		'{8'h1E, 1'b0, 7'h00, 1'b0, LED_CAPS_OFF},
		'{CODE_LSHIFT_BK, 1'b1, 7'h00, 1'b0, LED_CAPS_OFF},
		'{CODE_CAPS_MK, 1'b1, 7'h00, 1'b1, LED_CAPS_ON},
		'{8'h10, 1'b0, 7'h00, 1'b0, LED_CAPS_OFF},
		'{CODE_RSHIFT_MK, 1'b1, 7'h00, 1'b0, LED_CAPS_OFF},
		'{8'h10, 1'b0, 7'h00, 1'b0, LED_CAPS_OFF},          // shift and caps cancel
		'{8'h47, 1'b0, 7'h00, 1'b0, LED_CAPS_OFF},          // keypad digit
		'{CODE_RSHIFT_BK, 1'b1, 7'h00, 1'b0, LED_CAPS_OFF},
		'{8'h47, 1'b0, 7'h00, 1'b0, LED_CAPS_OFF},
		'{CODE_EXT_PREFIX, 1'b1, 7'h00, 1'b0, LED_CAPS_OFF},
		'{CODE_CAPS_MK, 1'b1, 7'h00, 1'b1, LED_CAPS_OFF},   // caps under a prefix
		'{8'h80, 1'b1, 7'h00, 1'b0, LED_CAPS_OFF},          // clears the prefix
		'{CODE_EXT_PREFIX, 1'b1, 7'h00, 1'b0, LED_CAPS_OFF},
		'{CODE_EXT_PREFIX, 1'b1, 7'h00, 1'b0, LED_CAPS_OFF}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] scan_code = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [6:0] ascii_char;
	logic       led_write;
	logic [2:0] led_mask;

	// Keyboard flags as the model sees them.
	logic prefix_seen = 1'b0;
	logic lshift_down = 1'b0;
	logic rshift_down = 1'b0;
	logic caps_active = 1'b0;

	stc_result_t decoded_queue [$];
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned cycle_count = 0;
	int unsigned codes_sent = 0;
	int unsigned beats_checked = 0;
	int unsigned chars_seen = 0;
	int unsigned led_writes_seen = 0;
	int unsigned fault_count = 0;

	scancode_to_ascii_decoder DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.scan_code  (scan_code),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ascii_char (ascii_char),
		.led_write  (led_write),
		.led_mask   (led_mask)
	);

	always #5 clk = ~clk;

	// Applies one scancode to the keyboard flags and returns the result it gives.
	function automatic stc_result_t decode_key(input logic [7:0] code);
		stc_result_t res;
		res = '0;
		case (code)
			CODE_EXT_PREFIX: prefix_seen = 1'b1;
			CODE_LSHIFT_MK:  lshift_down = 1'b1;
			CODE_RSHIFT_MK:  rshift_down = 1'b1;
			CODE_LSHIFT_BK:  lshift_down = 1'b0;
			CODE_RSHIFT_BK:  rshift_down = 1'b0;
			CODE_CAPS_MK: begin
				caps_active = ~caps_active;
				res.led_write = 1'b1;
				res.led_mask = caps_active ? LED_CAPS_ON : LED_CAPS_OFF;
			end
			default: begin
				if (prefix_seen) begin
					prefix_seen = 1'b0;
				end else if (!code[7] && int'(code) < KEY_COUNT) begin
					res.ascii_char = ((lshift_down | rshift_down) ^ caps_active) ?
						SHIFT_KEYS[code[6:0]] : LOWER_KEYS[code[6:0]];
				end
			end
		endcase
		return res;
	endfunction

	// Sends one scancode beat, with random idle cycles ahead of it, and queues its result.
	task automatic send_key(input logic [7:0] code, input logic fixed = 1'b0,
			input stc_result_t fixed_res = '0);
		stc_result_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		scan_code <= code;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		res = decode_key(code);
		decoded_queue.push_back(fixed ? fixed_res : res);
		codes_sent++;
	endtask

	function automatic logic [7:0] random_make();
		return 8'($urandom_range(KEY_COUNT - 1));
	endfunction

	// One random keyboard gesture: mostly typing, with shifted words, caps, prefixes and noise.
	task automatic send_gesture();
		int unsigned pick;
		int unsigned word_len;
		logic        use_left;
		pick = $urandom_range(99);
		if (pick < 45) begin
			send_key(random_make());
		end else if (pick < 55) begin
			send_key(8'h80 | random_make());
		end else if (pick < 67) begin
			use_left = 1'($urandom_range(1));
			word_len = $urandom_range(4, 1);
			send_key(use_left ? CODE_LSHIFT_MK : CODE_RSHIFT_MK);
			repeat (word_len) send_key(random_make());
			// Now and then the shift is left held across following gestures.
			if ($urandom_range(9) != 0) send_key(use_left ? CODE_LSHIFT_BK : CODE_RSHIFT_BK);
		end else if (pick < 72) begin
			send_key(CODE_CAPS_MK);
		end else if (pick < 82) begin
			send_key(CODE_EXT_PREFIX);
			send_key(8'($urandom_range(255)));
		end else begin
			send_key(8'($urandom_range(255)));
		end
	endtask

	// Result side: checks each accepted beat, then picks the next ready level.
	always @(posedge clk) begin
		stc_result_t want;
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: run stopped at the cycle limit, %0d results outstanding", $time,
				decoded_queue.size());
			$display("simulation failed");
			$finish;
		end else if (arst_n) begin
			if (out_valid && out_ready) begin
				if (decoded_queue.size() == 0) begin
					fault_count++;
					$display("%0t: unexpected result beat, char %h led %b mask %0d", $time,
						ascii_char, led_write, led_mask);
				end else begin
					want = decoded_queue.pop_front();
					beats_checked++;
					if (want.ascii_char != 0) chars_seen++;
					if (want.led_write) led_writes_seen++;
					if (ascii_char !== want.ascii_char) begin
						fault_count++;
						$display("%0t: ascii_char expected %h, got %h", $time,
							want.ascii_char, ascii_char);
					end
					if (led_write !== want.led_write) begin
						fault_count++;
						$display("%0t: led_write expected %b, got %b", $time,
							want.led_write, led_write);
					end
					if (led_mask !== want.led_mask) begin
						fault_count++;
						$display("%0t: led_mask expected %0d, got %0d", $time,
							want.led_mask, led_mask);
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Stimulus: reset, directed table, three random phases with different idling.
	initial begin
		stc_result_t row_res;
		int unsigned phase_goal;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 31;
		recv_idle_pct = 56;
		for (int i = 0; i < ROW_COUNT; i++) begin
			row_res.ascii_char = KEY_ROWS[i].ascii_char;
			row_res.led_write = KEY_ROWS[i].led_write;
			row_res.led_mask = KEY_ROWS[i].led_mask;
			send_key(KEY_ROWS[i].code, KEY_ROWS[i].fixed, row_res);
		end

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 56 : 0;
			recv_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 31 : 0;
			phase_goal = ROW_COUNT + (ITEM_GOAL - ROW_COUNT) * (phase + 1) / 3;
			while (codes_sent < phase_goal) send_gesture();
		end
		in_valid <= 1'b0;

		// Let the pipeline drain, then watch a little longer for stray beats.
		while (decoded_queue.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Checked %0d result beats from %0d scancodes (%0d directed).", beats_checked,
			codes_sent, ROW_COUNT);
		$display("They held %0d characters and %0d caps lock LED updates; %0d faults.",
			chars_seen, led_writes_seen, fault_count);
		if (fault_count == 0 && decoded_queue.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

[filelist.f]
hdl/stc_pkg.sv
hdl/stc_front.sv
hdl/stc_lookup.sv
hdl/scancode_to_ascii_decoder.sv
tb/sv/testbench.sv
